### rtl/b2ad_pkg.sv
// b2ad_pkg: shared widths, types and digit helpers for the binary to ascii decimal converter
// used by b2ad_cell and binary_to_ascii_decimal8_top; depends on nothing

package b2ad_pkg;

  localparam int VALUE_W    = 32;
  localparam int NUM_DIGITS = 8;
  localparam int DIGIT_W    = 4;
  localparam int BCD_W      = NUM_DIGITS * DIGIT_W;
  localparam int CHAR_W     = 6;
  localparam int NUM_CELLS  = VALUE_W;

  localparam logic [CHAR_W-1:0]  ASCII_ZERO = CHAR_W'(48);
  localparam logic [DIGIT_W-1:0] DIGIT_MAX  = DIGIT_W'(9);
  localparam logic [DIGIT_W-1:0] ADJ_LIMIT  = DIGIT_W'(5);
  localparam logic [DIGIT_W-1:0] ADJ_ADD    = DIGIT_W'(3);

  typedef struct packed {
    logic [BCD_W-1:0]   bcd;
    logic [VALUE_W-1:0] bin;
  } dd_word_t;

  typedef struct packed {
    logic     valid;
    dd_word_t word;
  } dd_fwd_t;

  function automatic logic [DIGIT_W-1:0] digit_adjust(input logic [DIGIT_W-1:0] d);
    logic [DIGIT_W-1:0] r;
    r = (d >= ADJ_LIMIT) ? DIGIT_W'(d + ADJ_ADD) : d;
    return r;
  endfunction

  function automatic logic [CHAR_W-1:0] digit_to_char(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] r;
    r = ASCII_ZERO + CHAR_W'(d);
    return r;
  endfunction

endpackage

### rtl/b2ad_cell.sv
// b2ad_cell: one shift-and-add-3 step of the binary to bcd conversion, with its own register
// depends on b2ad_pkg

module b2ad_cell (
  input  logic              clk,
  input  logic              rst,
  input  b2ad_pkg::dd_fwd_t up,
  output logic              up_ready,
  output b2ad_pkg::dd_fwd_t down,
  input  logic              down_ready
);
  import b2ad_pkg::*;

  logic     valid;
  dd_word_t word;
  dd_word_t word_next;
  logic [BCD_W-1:0] adj;

  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      adj[i*DIGIT_W +: DIGIT_W] = digit_adjust(up.word.bcd[i*DIGIT_W +: DIGIT_W]);
    end
    word_next.bcd = {adj[BCD_W-2:0], up.word.bin[VALUE_W-1]};
    word_next.bin = {up.word.bin[VALUE_W-2:0], 1'b0};
  end

  assign up_ready = !valid || down_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (up_ready) begin
      valid <= up.valid;
    end
    if (up_ready && up.valid) begin
      word <= word_next;
    end
  end

  assign down.valid = valid;
  assign down.word  = word;

  // held word stays put while downstream is blocked
  assert property (@(posedge clk) disable iff (rst)
    valid && !down_ready |=> valid && $stable(word))
    else $error("cell lost or changed a held word");

  // only a full, blocked cell refuses a transfer
  assert property (@(posedge clk) disable iff (rst)
    !up_ready |-> valid && !down_ready)
    else $error("cell stalled while able to move");

  // every bcd digit held stays a decimal digit
  assert property (@(posedge clk) disable iff (rst)
    valid |-> (word.bcd[3:0] <= DIGIT_MAX) && (word.bcd[7:4] <= DIGIT_MAX)
      && (word.bcd[11:8] <= DIGIT_MAX) && (word.bcd[15:12] <= DIGIT_MAX)
      && (word.bcd[19:16] <= DIGIT_MAX) && (word.bcd[23:20] <= DIGIT_MAX)
      && (word.bcd[27:24] <= DIGIT_MAX) && (word.bcd[31:28] <= DIGIT_MAX))
    else $error("cell holds a non-decimal digit");

endmodule

### rtl/binary_to_ascii_decimal8_top.sv
// binary_to_ascii_decimal8_top: 32-bit binary to eight ascii decimal characters
// row of b2ad_cell stages, one per input bit; depends on b2ad_pkg and b2ad_cell
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+---------------------------
//  in      | sink      | in_valid / in_stall   | value[31:0]
//  out     | source    | out_valid / out_stall | char_pos0..char_pos7 [5:0]
//
// one transfer per cycle in and out when not stalled
// a value passes through one registered cell per input bit
// each cell moves on when its neighbor is empty or moving, so bubbles close up
// rst is synchronous and empties every cell; no clearing pass
// out_stall backs up through full cells to in_stall in the same cycle

module binary_to_ascii_decimal8_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [b2ad_pkg::VALUE_W-1:0]  value,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [b2ad_pkg::CHAR_W-1:0]   char_pos0,
  output logic [b2ad_pkg::CHAR_W-1:0]   char_pos1,
  output logic [b2ad_pkg::CHAR_W-1:0]   char_pos2,
  output logic [b2ad_pkg::CHAR_W-1:0]   char_pos3,
  output logic [b2ad_pkg::CHAR_W-1:0]   char_pos4,
  output logic [b2ad_pkg::CHAR_W-1:0]   char_pos5,
  output logic [b2ad_pkg::CHAR_W-1:0]   char_pos6,
  output logic [b2ad_pkg::CHAR_W-1:0]   char_pos7
);
  import b2ad_pkg::*;

  dd_fwd_t fwd   [NUM_CELLS+1];
  logic    ready [NUM_CELLS+1];
  logic [BCD_W-1:0] bcd;

  assign fwd[0].valid    = in_valid;
  assign fwd[0].word.bcd = '0;
  assign fwd[0].word.bin = value;
  assign in_stall        = !ready[0];
  assign ready[NUM_CELLS] = !out_stall;

  for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
    b2ad_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .up         (fwd[k]),
      .up_ready   (ready[k]),
      .down       (fwd[k+1]),
      .down_ready (ready[k+1])
    );
  end

  assign out_valid = fwd[NUM_CELLS].valid;
  assign bcd       = fwd[NUM_CELLS].word.bcd;

  assign char_pos0 = digit_to_char(bcd[31:28]);
  assign char_pos1 = digit_to_char(bcd[27:24]);
  assign char_pos2 = digit_to_char(bcd[23:20]);
  assign char_pos3 = digit_to_char(bcd[19:16]);
  assign char_pos4 = digit_to_char(bcd[15:12]);
  assign char_pos5 = digit_to_char(bcd[11:8]);
  assign char_pos6 = digit_to_char(bcd[7:4]);
  assign char_pos7 = digit_to_char(bcd[3:0]);

endmodule

### tb/tb_binary_to_ascii_decimal8_top.sv
// tb_binary_to_ascii_decimal8_top: self-checking bench for the binary to ascii decimal converter
// scoreboard class predicts eight ascii digits per value; tasks drive valid/stall traffic
// depends on b2ad_pkg and binary_to_ascii_decimal8_top
`timescale 1ns / 1ps

module tb_binary_to_ascii_decimal8_top;
  import b2ad_pkg::*;

  localparam int IDLE_LIMIT = 2000;
  localparam int HOLD_LEN   = 200;

  typedef logic [NUM_DIGITS-1:0][CHAR_W-1:0] chars_t;

  typedef struct {
    logic [VALUE_W-1:0] value;
    chars_t             chars;
  } pending_t;

  class decimal_scoreboard;
    pending_t expected_chars[$];
    int       errors;

    function new();
      errors = 0;
    endfunction

    // low eight decimal digits, most significant at position 0
    function chars_t decimal_chars(logic [VALUE_W-1:0] v);
      chars_t             c;
      logic [VALUE_W-1:0] rest;
      rest = v;
      for (int p = NUM_DIGITS - 1; p >= 0; p--) begin
        c[p] = CHAR_W'(ASCII_ZERO + rest % 10);
        rest = rest / 10;
      end
      return c;
    endfunction

    function void note_value(logic [VALUE_W-1:0] v);
      pending_t e;
      e.value = v;
      e.chars = decimal_chars(v);
      expected_chars.push_back(e);
    endfunction

    function void check_chars(chars_t got);
      pending_t e;
      if (expected_chars.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
        return;
      end
      e = expected_chars.pop_front();
      for (int p = 0; p < NUM_DIGITS; p++) begin
        if (got[p] !== e.chars[p]) begin
          $display("%0t: value %0d char_pos%0d expected %0d actual %0d",
                   $time, e.value, p, e.chars[p], got[p]);
          errors++;
        end
      end
    endfunction

    function int pending();
      return expected_chars.size();
    endfunction
  endclass

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  logic [VALUE_W-1:0] value;
  logic               out_valid;
  logic               out_stall;
  logic [CHAR_W-1:0]  char_pos0, char_pos1, char_pos2, char_pos3;
  logic [CHAR_W-1:0]  char_pos4, char_pos5, char_pos6, char_pos7;

  decimal_scoreboard sb;
  int                stall_pct;
  int                hold_cycles;
  int                idle_cycles;

  binary_to_ascii_decimal8_top dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .value     (value),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .char_pos0 (char_pos0),
    .char_pos1 (char_pos1),
    .char_pos2 (char_pos2),
    .char_pos3 (char_pos3),
    .char_pos4 (char_pos4),
    .char_pos5 (char_pos5),
    .char_pos6 (char_pos6),
    .char_pos7 (char_pos7)
  );

  initial begin
    clk = 1'b0;
  end

  always #5 clk = ~clk;

  // receiver: random stall, or a long hold-off when requested
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_stall <= 1'b1;
        hold_cycles--;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  // result monitor and idle watchdog
  always @(posedge clk) begin : monitor
    chars_t got;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        got[0] = char_pos0;
        got[1] = char_pos1;
        got[2] = char_pos2;
        got[3] = char_pos3;
        got[4] = char_pos4;
        got[5] = char_pos5;
        got[6] = char_pos6;
        got[7] = char_pos7;
        sb.check_chars(got);
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  task automatic send_value(input logic [VALUE_W-1:0] v, input int gap_pct);
    while ($urandom_range(99) < gap_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
      value    <= $urandom;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    value    <= v;
    do @(posedge clk); while (in_stall);
    sb.note_value(v);
  endtask

  task automatic pause_sender();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic wait_results();
    while (sb.pending() > 0) @(posedge clk);
  endtask

  function automatic logic [VALUE_W-1:0] rand_value();
    int unsigned        pick;
    int unsigned        k;
    logic [VALUE_W-1:0] base;
    pick = $urandom_range(99);
    if (pick < 50) return $urandom;
    if (pick < 75) return $urandom_range(99999999);
    if (pick < 85) return $urandom_range(999);
    // near a power of ten
    k    = $urandom_range(9);
    base = 1;
    repeat (k) base = base * 10;
    return base + $urandom_range(4) - 2;
  endfunction

  task automatic random_phase(input int count, input int gap_pct, input int stall);
    stall_pct = stall;
    repeat (count) send_value(rand_value(), gap_pct);
    pause_sender();
    wait_results();
  endtask

  initial begin
    logic [VALUE_W-1:0] directed[$];
    sb          = new();
    rst         = 1'b1;
    in_valid    = 1'b0;
    value       = '0;
    stall_pct   = 0;
    hold_cycles = 0;
    idle_cycles = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    directed = '{32'd0, 32'd1, 32'd9, 32'd10, 32'd12345678, 32'd87654321,
                 32'd90909090, 32'd9999999, 32'd10000000, 32'd99999999,
                 32'd100000000, 32'd100000001, 32'd199999999, 32'd99999990,
                 32'd1000000000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                 32'hAAAA_AAAA, 32'h5555_5555};
    foreach (directed[i]) send_value(directed[i], 0);
    pause_sender();
    wait_results();

    random_phase(140, 0, 0);
    random_phase(140, 55, 0);

    // long receiver hold-off while values keep coming, then drain
    hold_cycles = HOLD_LEN;
    stall_pct   = 0;
    repeat (60) send_value(rand_value(), 0);
    pause_sender();
    wait_results();

    random_phase(140, 0, 55);
    random_phase(140, 9, 9);

    repeat (40) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
